// ===== rtl/core/isb_pkg.sv =====
// Shared constants and codes for the indexed block search unit.
package isb_pkg;

	localparam int DATA_DEPTH = 256;
	localparam int MAX_BLOCKS = 16;

	localparam int KEY_W   = 32;
	localparam int ADDR_W  = 8;
	localparam int LEN_W   = 9;
	localparam int CFG_W   = 5;
	localparam int BLK_W   = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W   = BLK_W + 1;
	localparam int DATA_AW = $clog2(DATA_DEPTH);
	localparam int MAX_LEN = 256;

	localparam logic [1:0] MODE_WR_DATA  = 2'd0;
	localparam logic [1:0] MODE_WR_INDEX = 2'd1;
	localparam logic [1:0] MODE_SEARCH   = 2'd2;

	localparam logic [1:0] STAT_FOUND        = 2'd0;
	localparam logic [1:0] STAT_NO_BLOCK     = 2'd1;
	localparam logic [1:0] STAT_NOT_IN_BLOCK = 2'd2;
	localparam logic [1:0] STAT_WR_ACK       = 2'd3;

endpackage

// ===== rtl/core/isb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module isb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/core/indexed_block_search_unit.sv =====
// Indexed block search: index binary search followed by a sequential block scan.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------------
//  in      | request   | in_valid / in_stall    | mode, slot, key_value, block_start,
//          |           |                        | block_length
//  out     | response  | out_valid / out_stall  | status, position, block_number
//  cfg     | write     | cfg_wr_en              | cfg_wr_data (blocks_in_use)
//
// Write requests are answered in the cycle after they are accepted. A search makes at most one
// compare per cycle: up to 1 + log2(MAX_BLOCKS) index probes and a step to pick the block, then a
// scan of the block's words (its length, capped at MAX_LEN) through the one RAM read port, then
// the output register. No new request is taken while a search is in progress.
// Reset clears control state only; stored data and index entries are undefined until written.
// A held response blocks every new request until it is taken.
module indexed_block_search_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [isb_pkg::CFG_W-1:0]   cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  mode,
	input  logic [7:0]                  slot,
	input  logic signed [31:0]          key_value,
	input  logic [7:0]                  block_start,
	input  logic [8:0]                  block_length,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [7:0]                  position,
	output logic [3:0]                  block_number
);

	import isb_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BSEARCH,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                   state_q;
	logic [CFG_W-1:0]         blocks_q;
	logic signed [KEY_W-1:0]  key_q;
	logic [CNT_W-1:0]         lo_q;
	logic [CNT_W-1:0]         hi_q;
	logic [CNT_W-1:0]         n_q;
	logic [BLK_W-1:0]         blk_q;
	logic [ADDR_W-1:0]        start_q;
	logic [LEN_W-1:0]         len_q;
	logic [LEN_W-1:0]         j_q;
	logic                     cmp_vld_q;
	logic [ADDR_W-1:0]        cmp_addr_q;
	logic                     out_valid_q;
	logic [1:0]               status_q;
	logic [7:0]               position_q;
	logic [3:0]               block_number_q;

	logic signed [KEY_W-1:0]  idx_key_q [MAX_BLOCKS];
	logic [ADDR_W-1:0]        idx_start_q [MAX_BLOCKS];
	logic [LEN_W-1:0]         idx_len_q [MAX_BLOCKS];

	logic                     in_accept;
	logic                     out_free;
	logic                     out_set;
	logic [CNT_W-1:0]         n_eff;
	logic [CNT_W-1:0]         mid_sum;
	logic [BLK_W-1:0]         mid;
	logic [BLK_W-1:0]         lo_blk;
	logic [LEN_W-1:0]         len_sat;
	logic [ADDR_W-1:0]        scan_addr;
	logic                     data_wr_en;
	logic [KEY_W-1:0]         rd_data;
	logic                     hit;

	assign out_free   = !out_valid_q || !out_stall;
	assign in_stall   = (state_q != ST_IDLE) || !out_free;
	assign in_accept  = in_valid && !in_stall;
	assign out_set    = ((state_q == ST_IDLE) && in_accept && (mode != MODE_SEARCH))
	                    || ((state_q == ST_DONE) && out_free);

	assign n_eff      = (blocks_q > CFG_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : CNT_W'(blocks_q);
	assign mid_sum    = CNT_W'((lo_q + hi_q) >> 1);
	assign mid        = mid_sum[BLK_W-1:0];
	assign lo_blk     = lo_q[BLK_W-1:0];
	assign len_sat    = (idx_len_q[lo_blk] > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN)
	                                                           : idx_len_q[lo_blk];
	assign scan_addr  = ADDR_W'(start_q + j_q[ADDR_W-1:0]);
	assign data_wr_en = in_accept && (mode == MODE_WR_DATA) && (int'(slot) < DATA_DEPTH);
	assign hit        = cmp_vld_q && (int'(cmp_addr_q) < DATA_DEPTH)
	                    && ($signed(rd_data) == key_q);

	isb_ram #(
		.WIDTH (KEY_W),
		.DEPTH (DATA_DEPTH),
		.AW    (DATA_AW)
	) u_data_ram (
		.clk     (clk),
		.wr_en   (data_wr_en),
		.wr_addr (slot[DATA_AW-1:0]),
		.wr_data (key_value),
		.rd_addr (scan_addr[DATA_AW-1:0]),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk) begin
		if (in_accept && (mode == MODE_WR_INDEX) && (int'(slot) < MAX_BLOCKS)) begin
			idx_key_q[slot[BLK_W-1:0]]   <= key_value;
			idx_start_q[slot[BLK_W-1:0]] <= block_start;
			idx_len_q[slot[BLK_W-1:0]]   <= block_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocks_q <= CFG_W'(1);
		end else if (cfg_wr_en) begin
			blocks_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			status_q       <= STAT_WR_ACK;
			position_q     <= '0;
			block_number_q <= '0;
			lo_q           <= '0;
			hi_q           <= '0;
			n_q            <= '0;
			j_q            <= '0;
			len_q          <= '0;
			cmp_vld_q      <= 1'b0;
		end else begin
			out_valid_q <= out_set || (out_valid_q && out_stall);
			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						if (mode == MODE_SEARCH) begin
							key_q   <= key_value;
							lo_q    <= '0;
							hi_q    <= n_eff;
							n_q     <= n_eff;
							state_q <= ST_BSEARCH;
						end else begin
							status_q       <= STAT_WR_ACK;
							position_q     <= '0;
							block_number_q <= '0;
						end
					end
				end
				ST_BSEARCH: begin
					if (lo_q < hi_q) begin
						if (idx_key_q[mid] < key_q) begin
							lo_q <= CNT_W'(mid_sum + 1'b1);
						end else begin
							hi_q <= mid_sum;
						end
					end else if (lo_q >= n_q) begin
						status_q       <= STAT_NO_BLOCK;
						position_q     <= '0;
						block_number_q <= '0;
						state_q        <= ST_DONE;
					end else begin
						blk_q     <= lo_blk;
						start_q   <= idx_start_q[lo_blk];
						len_q     <= len_sat;
						j_q       <= '0;
						cmp_vld_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (hit) begin
						status_q       <= STAT_FOUND;
						position_q     <= cmp_addr_q;
						block_number_q <= 4'(blk_q);
						cmp_vld_q      <= 1'b0;
						state_q        <= ST_DONE;
					end else if (j_q < len_q) begin
						cmp_vld_q  <= 1'b1;
						cmp_addr_q <= scan_addr;
						j_q        <= LEN_W'(j_q + 1'b1);
					end else if (cmp_vld_q) begin
						cmp_vld_q <= 1'b0;
					end else begin
						status_q       <= STAT_NOT_IN_BLOCK;
						position_q     <= '0;
						block_number_q <= 4'(blk_q);
						state_q        <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign position     = position_q;
	assign block_number = block_number_q;

	a_bsearch_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_BSEARCH |-> (lo_q <= hi_q) && (hi_q <= n_q))
		else $error("binary search bounds out of order");

	a_scan_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> j_q <= len_q)
		else $error("scan offset beyond block length");

	a_no_block_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q == STAT_NO_BLOCK) |-> (position_q == '0)
		&& (block_number_q == '0))
		else $error("no_block response carries nonzero fields");

	a_search_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) && out_free |=> out_valid_q && (state_q == ST_IDLE))
		else $error("finished search not delivered");

endmodule

// ===== tb/sv/tb_indexed_block_search_unit.sv =====
// Testbench for the indexed block search unit: directed and random requests checked by a scoreboard.
module tb_indexed_block_search_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import isb_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int ITEM_TARGET = 1850;
	localparam int CYCLE_LIMIT = 3_000_000;

	typedef struct {
		logic [1:0]         mode;
		logic [7:0]         slot;
		logic signed [31:0] key_value;
		logic [7:0]         block_start;
		logic [8:0]         block_length;
	} request_t;

	typedef struct {
		logic [1:0] status;
		logic [7:0] position;
		logic [3:0] block_number;
	} response_t;

	class search_tracker;
		int        data_word[DATA_DEPTH];
		bit        data_valid[DATA_DEPTH];
		int        largest_key[MAX_BLOCKS];
		bit [7:0]  first_addr[MAX_BLOCKS];
		bit [8:0]  word_count[MAX_BLOCKS];
		bit        entry_valid[MAX_BLOCKS];
		bit [4:0]  blocks_in_use;
		response_t pending[$];
		int        error_count;

		function new();
			blocks_in_use = 5'd1;
			error_count = 0;
		endfunction

		function int searched_blocks();
			return (blocks_in_use > MAX_BLOCKS) ? MAX_BLOCKS : int'(blocks_in_use);
		endfunction

		function int block_span(int b);
			return (word_count[b] > 9'd256) ? 256 : int'(word_count[b]);
		endfunction

		function int locate_block(int key);
			int lo = 0;
			int hi = searched_blocks();
			int mid;
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if (largest_key[mid] < key)
					lo = mid + 1;
				else
					hi = mid;
			end
			return lo;
		endfunction

		function bit search_is_defined(int key);
			int n = searched_blocks();
			int b;
			for (int i = 0; i < n; i++)
				if (!entry_valid[i])
					return 1'b0;
			b = locate_block(key);
			if (b >= n)
				return 1'b1;
			for (int j = 0; j < block_span(b); j++)
				if (!data_valid[8'(first_addr[b] + j)])
					return 1'b0;
			return 1'b1;
		endfunction

		function void note_request(request_t r);
			response_t want = '{STAT_WR_ACK, 8'd0, 4'd0};
			int n = searched_blocks();
			int b;
			bit [7:0] addr;
			case (r.mode)
				MODE_WR_DATA: begin
					if (r.slot < DATA_DEPTH) begin
						data_word[r.slot] = r.key_value;
						data_valid[r.slot] = 1'b1;
					end
				end
				MODE_WR_INDEX: begin
					if (r.slot < MAX_BLOCKS) begin
						largest_key[r.slot] = r.key_value;
						first_addr[r.slot] = r.block_start;
						word_count[r.slot] = r.block_length;
						entry_valid[r.slot] = 1'b1;
					end
				end
				MODE_SEARCH: begin
					b = locate_block(r.key_value);
					if (b >= n) begin
						want.status = STAT_NO_BLOCK;
					end else begin
						want.status = STAT_NOT_IN_BLOCK;
						want.block_number = 4'(b);
						for (int j = 0; j < block_span(b); j++) begin
							addr = 8'(first_addr[b] + j);
							if (data_word[addr] == r.key_value) begin
								want.status = STAT_FOUND;
								want.position = addr;
								break;
							end
						end
					end
				end
				default: ;
			endcase
			pending.push_back(want);
		endfunction

		task report_mismatch(string what);
			error_count++;
			$display("MISMATCH at %0t: %s", $time, what);
		endtask

		task check_response(response_t got);
			response_t want;
			if (pending.size() == 0) begin
				report_mismatch("response with no request pending");
				return;
			end
			want = pending.pop_front();
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
			if (got.position !== want.position)
				report_mismatch($sformatf("position %0d, expected %0d",
					got.position, want.position));
			if (got.block_number !== want.block_number)
				report_mismatch($sformatf("block_number %0d, expected %0d",
					got.block_number, want.block_number));
		endtask
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_wr_en = 1'b0;
	logic [CFG_W-1:0]   cfg_wr_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         mode = '0;
	logic [7:0]         slot = '0;
	logic signed [31:0] key_value = '0;
	logic [7:0]         block_start = '0;
	logic [8:0]         block_length = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         status;
	logic [7:0]         position;
	logic [3:0]         block_number;

	search_tracker tracker;
	int send_idle_pct = 28;
	int recv_idle_pct = 67;
	int items_sent = 0;
	int cycle_count = 0;

	indexed_block_search_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.mode         (mode),
		.slot         (slot),
		.key_value    (key_value),
		.block_start  (block_start),
		.block_length (block_length),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.position     (position),
		.block_number (block_number)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin : watch_responses
		response_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen.status = status;
			seen.position = position;
			seen.block_number = block_number;
			tracker.check_response(seen);
		end
	end

	function automatic request_t make_request(logic [1:0] op, logic [7:0] where, int key,
			logic [7:0] start_addr, logic [8:0] words);
		request_t r;
		r.mode = op;
		r.slot = where;
		r.key_value = key;
		r.block_start = start_addr;
		r.block_length = words;
		return r;
	endfunction

	function automatic logic [8:0] pick_length();
		int p = $urandom_range(0, 99);
		if (p < 3)
			return 9'($urandom_range(256, 511));
		if (p < 12)
			return 9'($urandom_range(21, 255));
		return 9'($urandom_range(0, 20));
	endfunction

	task automatic send_request(request_t r);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= r.mode;
		slot <= r.slot;
		key_value <= r.key_value;
		block_start <= r.block_start;
		block_length <= r.block_length;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tracker.note_request(r);
		if (r.mode != MODE_SPARE && !(r.mode == MODE_WR_INDEX && r.slot >= MAX_BLOCKS))
			items_sent++;
	endtask

	initial begin : stimulus
		int round_no = 0;
		int keys[$];
		int b;
		int n;
		int span;
		int pick;
		int key;
		logic [4:0] setting;
		logic [8:0] words;

		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_request(make_request(MODE_WR_DATA, 8'd0, 32'sh8000_0000, 8'h00, 9'h000));
		send_request(make_request(MODE_WR_DATA, 8'd255, 32'sh7FFF_FFFF, 8'hFF, 9'h1FF));
		send_request(make_request(MODE_WR_DATA, 8'd1, -1, 8'h00, 9'h000));
		send_request(make_request(MODE_WR_DATA, 8'd254, 0, 8'hFF, 9'h1FF));
		send_request(make_request(MODE_WR_INDEX, 8'd0, 32'sh7FFF_FFFF, 8'd254, 9'd4));
		send_request(make_request(MODE_SPARE, 8'hFF, -1, 8'hFF, 9'h1FF));
		send_request(make_request(MODE_WR_INDEX, 8'd16, 5, 8'd0, 9'd511));
		send_request(make_request(MODE_WR_INDEX, 8'd255, -5, 8'd255, 9'd0));
		send_request(make_request(MODE_SEARCH, 8'hFF, -1, 8'h00, 9'h1FF));
		send_request(make_request(MODE_SEARCH, 8'h00, 32'sh8000_0000, 8'hFF, 9'h000));
		send_request(make_request(MODE_SEARCH, 8'hFF, 32'sh7FFF_FFFF, 8'h00, 9'h1FF));
		send_request(make_request(MODE_SEARCH, 8'h00, 0, 8'hFF, 9'h000));
		send_request(make_request(MODE_SEARCH, 8'h5A, 12345, 8'hA5, 9'h0AA));
		send_request(make_request(MODE_WR_INDEX, 8'd0, -2, 8'd0, 9'd0));
		send_request(make_request(MODE_SEARCH, 8'h00, 5, 8'h00, 9'h000));
		send_request(make_request(MODE_SEARCH, 8'h00, 32'sh7FFF_FFFF, 8'h00, 9'h000));
		send_request(make_request(MODE_SEARCH, 8'h00, -2, 8'h00, 9'h000));
		send_request(make_request(MODE_WR_INDEX, 8'd0, 32'sh7FFF_FFFF, 8'd1, 9'd1));
		send_request(make_request(MODE_SEARCH, 8'h00, -1, 8'h00, 9'h000));
		send_request(make_request(MODE_SEARCH, 8'h00, 32'sh8000_0000, 8'h00, 9'h000));

		while (items_sent < ITEM_TARGET) begin
			if (items_sent < ITEM_TARGET / 3) begin
				send_idle_pct = 28;
				recv_idle_pct = 67;
			end else if (items_sent < 2 * ITEM_TARGET / 3) begin
				send_idle_pct = 67;
				recv_idle_pct = 28;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end

			pick = $urandom_range(0, 9);
			case (round_no)
				0: setting = 5'd16;
				1: setting = 5'd31;
				2: setting = 5'd0;
				3: setting = 5'd1;
				default: begin
					if (pick < 6)
						setting = 5'($urandom_range(2, 16));
					else if (pick < 9)
						setting = 5'($urandom_range(17, 31));
					else
						setting = 5'($urandom_range(0, 1));
				end
			endcase
			in_valid <= 1'b0;
			while (tracker.pending.size() != 0)
				@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= setting;
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			tracker.blocks_in_use = setting;

			if (round_no == 0)
				for (int a = 0; a < DATA_DEPTH; a++)
					send_request(make_request(MODE_WR_DATA, 8'(a),
						int'($urandom_range(0, 160)) - 80, 8'($urandom()), 9'($urandom())));

			keys.delete();
			for (int i = 0; i < MAX_BLOCKS; i++)
				keys.push_back((round_no % 3 == 1) ? int'($urandom())
					: int'($urandom_range(0, 160)) - 80);
			keys.sort();
			if (round_no % 3 == 1 && $urandom_range(0, 1) == 1)
				keys[0] = 32'sh8000_0000;
			if (round_no % 3 == 1 && $urandom_range(0, 1) == 1)
				keys[MAX_BLOCKS-1] = 32'sh7FFF_FFFF;
			for (int i = 0; i < MAX_BLOCKS; i++) begin
				words = pick_length();
				if (round_no == 0 && i == MAX_BLOCKS - 1)
					words = 9'd511;
				if (round_no == 0 && i == MAX_BLOCKS - 2)
					words = 9'd256;
				send_request(make_request(MODE_WR_INDEX, 8'(i), keys[i], 8'($urandom()), words));
			end

			repeat ($urandom_range(10, 30)) begin
				b = $urandom_range(0, MAX_BLOCKS - 1);
				span = tracker.block_span(b);
				key = tracker.largest_key[b] - int'($urandom_range(0, 4));
				if ($urandom_range(0, 9) == 0)
					key = int'($urandom());
				if (span > 0)
					send_request(make_request(MODE_WR_DATA,
						8'(tracker.first_addr[b] + $urandom_range(0, span - 1)), key,
						8'($urandom()), 9'($urandom())));
			end

			repeat ($urandom_range(25, 50)) begin
				pick = $urandom_range(0, 99);
				b = $urandom_range(0, MAX_BLOCKS - 1);
				n = tracker.searched_blocks();
				span = tracker.block_span(b);
				key = int'($urandom());
				if (pick < 5)
					send_request(make_request(MODE_SPARE, 8'($urandom()), int'($urandom()),
						8'($urandom()), 9'($urandom())));
				else if (pick < 8)
					send_request(make_request(MODE_WR_INDEX, 8'($urandom_range(MAX_BLOCKS, 255)),
						int'($urandom()), 8'($urandom()), 9'($urandom())));
				else if (pick < 10)
					send_request(make_request(MODE_WR_DATA, 8'($urandom()), int'($urandom()),
						8'($urandom()), 9'($urandom())));
				else if (pick < 11)
					send_request(make_request(MODE_WR_INDEX, 8'($urandom_range(0, MAX_BLOCKS - 1)),
						int'($urandom()), 8'($urandom()), pick_length()));
				else begin
					if (pick < 55 && span > 0)
						key = tracker.data_word[8'(tracker.first_addr[b]
							+ $urandom_range(0, span - 1))];
					else if (pick < 68)
						key = tracker.largest_key[b];
					else if (pick < 78 && n > 0)
						key = tracker.largest_key[n-1] + int'($urandom_range(1, 3));
					else if (pick < 90)
						key = tracker.data_word[$urandom_range(0, DATA_DEPTH - 1)];
					if (tracker.search_is_defined(key))
						send_request(make_request(MODE_SEARCH, 8'($urandom()), key,
							8'($urandom()), 9'($urandom())));
				end
			end
			round_no++;
		end

		in_valid <= 1'b0;
		while (tracker.pending.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (tracker.error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/core/isb_pkg.sv
rtl/core/isb_ram.sv
rtl/core/indexed_block_search_unit.sv
tb/sv/tb_indexed_block_search_unit.sv
